### sv/assert_macros.svh
// Assertion macros shared by the cache controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define WBSC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cache controller check failed");

// When the first condition holds, the second holds in the same cycle.
`define WBSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache controller check failed");

// When the first condition holds, the second holds in the next cycle.
`define WBSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache controller check failed");

`endif

### sv/wbsc_pkg.sv
// Shared types and constants of the write-back sector cache controller.
package wbsc_pkg;

  localparam int ACTION_W = 2;
  localparam int SECTOR_W = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W = 5;
  localparam int ESEC_W = 10;

  // Upper bound on entry results that one flush reports.
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Requested operation of an item.
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    RES_HIT         = 3'd0,
    RES_FILLED      = 3'd1,
    RES_RANGE       = 3'd2,
    RES_BYPASS      = 3'd3,
    RES_FETCH_FAIL  = 3'd4,
    RES_FLUSH_ENTRY = 3'd5,
    RES_FLUSH_DONE  = 3'd6
  } status_t;

  // One result item.
  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic                evict_valid;
    logic [ESEC_W-1:0]   evict_sector;
    logic                last;
  } result_t;

endpackage

### sv/wbsc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module wbsc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/wbsc_out_reg.sv
// Output register that holds one result item until the consumer takes it.
module wbsc_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  wbsc_pkg::result_t                   din,
  output logic                                out_free,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wbsc_pkg::STATUS_W-1:0]       status,
  output logic [wbsc_pkg::SLOT_W-1:0]         slot,
  output logic                                evict_valid,
  output logic [wbsc_pkg::ESEC_W-1:0]         evict_sector,
  output logic                                last
);

  wbsc_pkg::result_t res;

  // The register can take a new item when empty or when its item leaves now.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (push) begin
      res <= din;
    end
  end

  assign status       = res.status;
  assign slot         = res.slot;
  assign evict_valid  = res.evict_valid;
  assign evict_sector = res.evict_sector;
  assign last         = res.last;

endmodule

### sv/write_back_sector_cache_fifo_unit.sv
// Top level of the write-back sector cache tag and policy controller.
//
// Tags and dirty marks live in one SLOTS-deep RAM with a registered read; valid
// marks are flip-flops cleared by reset, so no clearing pass is needed. Items
// are handled one at a time. A read or write walks the tags one slot per
// cycle through the RAM read port. It passes through a dispatch state, the
// tag walk, a victim step on a fill, a state that hands the result to the
// output register, and the idle state that takes the next item. A flush also
// walks all slots once, one per cycle, and reports each dirty entry; it waits
// while a found entry cannot be handed to a full output register. Out-of-range
// and bypass items go from the dispatch state straight to the result state,
// and ignored items go back to idle with no result. The next item is accepted
// while the last result still sits in the output register.
`include "assert_macros.svh"

module write_back_sector_cache_fifo_unit #(
  parameter int SLOTS = 32,
  parameter int DISK_SIZE = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  // Input item channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wbsc_pkg::ACTION_W-1:0]       action,
  input  logic [wbsc_pkg::SECTOR_W-1:0]       sector,
  input  logic                                fetch_ok,
  input  logic                                writeback_ok,
  // Result item channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wbsc_pkg::STATUS_W-1:0]       status,
  output logic [wbsc_pkg::SLOT_W-1:0]         slot,
  output logic                                evict_valid,
  output logic [wbsc_pkg::ESEC_W-1:0]         evict_sector,
  output logic                                last
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int TAG_W = $clog2(DISK_SIZE);
  localparam int ENT_W = TAG_W + 1;
  localparam int CMP_W = wbsc_pkg::SECTOR_W + 1;
  localparam int CNT_W = wbsc_pkg::CNT_W;
  localparam int SLOT_W = wbsc_pkg::SLOT_W;
  localparam int ESEC_W = wbsc_pkg::ESEC_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CMP_W-1:0] SECTOR_LIMIT = CMP_W'(DISK_SIZE);
  localparam logic [CNT_W-1:0] CAP_LAST = CNT_W'(wbsc_pkg::MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOOK,
    S_VICTIM,
    S_FLUSH,
    S_FLUSH_END,
    S_RESP
  } state_t;

  function automatic wbsc_pkg::result_t mk_res(
    wbsc_pkg::status_t st,
    logic [SLOT_W-1:0] sl,
    logic              ev,
    logic [ESEC_W-1:0] es,
    logic              lst
  );
    return '{status: st, slot: sl, evict_valid: ev, evict_sector: es, last: lst};
  endfunction

  state_t                        state;
  logic                          persistence_on;
  logic [wbsc_pkg::ACTION_W-1:0] act;
  logic [wbsc_pkg::SECTOR_W-1:0] sec;
  logic                          fetch;
  logic                          wb;
  logic [IDX_W-1:0]              chk_idx;
  logic [IDX_W-1:0]              ptr;
  logic [SLOTS-1:0]              valid;
  wbsc_pkg::result_t             resp;
  wbsc_pkg::result_t             pend;
  logic                          pend_valid;
  logic [CNT_W-1:0]              fl_cnt;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [ENT_W-1:0]              ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [ENT_W-1:0]              ram_rdata;
  logic                          push;
  wbsc_pkg::result_t             push_res;
  logic                          out_free;

  logic [TAG_W-1:0]              rd_tag;
  logic                          rd_dirty;
  logic [TAG_W-1:0]              sec_tag;
  logic                          in_range;
  logic                          chk_last;
  logic                          look_match;
  logic                          fl_hit;
  logic                          fl_stall;
  logic                          fl_done;
  logic                          victim_ev;
  logic [IDX_W-1:0]              idx_inc;
  logic [IDX_W-1:0]              ptr_inc;
  wbsc_pkg::result_t             hit_res;
  wbsc_pkg::result_t             fill_res;
  wbsc_pkg::result_t             entry_res;
  wbsc_pkg::result_t             done_res;
  wbsc_pkg::result_t             final_res;

  // Tag and dirty store.
  wbsc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register toward the consumer.
  wbsc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .din          (push_res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot         (slot),
    .evict_valid  (evict_valid),
    .evict_sector (evict_sector),
    .last         (last)
  );

  // Neither channel takes anything while reset is held.
  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != S_IDLE);

  // Decode of the entry read back from the RAM and of the held item.
  assign rd_tag     = ram_rdata[ENT_W-1:1];
  assign rd_dirty   = ram_rdata[0];
  assign sec_tag    = sec[TAG_W-1:0];
  assign in_range   = {1'b0, sec} < SECTOR_LIMIT;
  assign chk_last   = (chk_idx == LAST_IDX);
  assign look_match = valid[chk_idx] && (rd_tag == sec_tag);
  assign idx_inc    = chk_idx + 1'b1;
  assign ptr_inc    = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
  assign victim_ev  = valid[ptr] && rd_dirty;

  // Flush walk: a dirty entry found while an earlier one still waits for the
  // full output register holds the walk and rereads the same slot.
  assign fl_hit   = valid[chk_idx] && rd_dirty;
  assign fl_stall = fl_hit && pend_valid && !out_free;
  assign fl_done  = chk_last || (fl_hit && (fl_cnt == CAP_LAST));

  // Result templates.
  assign hit_res   = mk_res(wbsc_pkg::RES_HIT, SLOT_W'(chk_idx), 1'b0, '0, 1'b1);
  assign fill_res  = mk_res(wbsc_pkg::RES_FILLED, SLOT_W'(ptr), victim_ev,
                            victim_ev ? ESEC_W'(rd_tag) : '0, 1'b1);
  assign entry_res = mk_res(wbsc_pkg::RES_FLUSH_ENTRY, SLOT_W'(chk_idx), 1'b1,
                            ESEC_W'(rd_tag), 1'b0);
  assign done_res  = mk_res(wbsc_pkg::RES_FLUSH_DONE, '0, 1'b0, '0, 1'b1);

  always_comb begin
    final_res = pend;
    final_res.last = 1'b1;
  end

  // RAM port control and result pushes.
  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = {sec_tag, 1'b0};
    push      = 1'b0;
    push_res  = resp;
    unique case (state)
      S_IDLE: begin
      end
      S_DISPATCH: begin
        ram_raddr = '0;
      end
      S_LOOK: begin
        ram_raddr = (!look_match && chk_last) ? ptr : idx_inc;
        if (look_match && act == wbsc_pkg::ACT_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = {sec_tag, 1'b1};
        end
      end
      S_VICTIM: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = {sec_tag, act == wbsc_pkg::ACT_WRITE};
      end
      S_FLUSH: begin
        ram_raddr = fl_stall ? chk_idx : idx_inc;
        if (fl_hit && !fl_stall) begin
          if (pend_valid) begin
            push     = 1'b1;
            push_res = pend;
          end
          if (wb) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_tag, 1'b0};
          end
        end
      end
      S_FLUSH_END: begin
        push     = out_free;
        push_res = pend_valid ? final_res : done_res;
      end
      S_RESP: begin
        push = out_free;
      end
    endcase
  end

  // Sequencer, replacement pointer, valid marks and held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      persistence_on <= 1'b0;
      ptr            <= '0;
      valid          <= '0;
      chk_idx        <= '0;
      pend_valid     <= 1'b0;
      fl_cnt         <= '0;
    end else begin
      if (cfg_valid) begin
        persistence_on <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act   <= action;
            sec   <= sector;
            fetch <= fetch_ok;
            wb    <= writeback_ok;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          chk_idx    <= '0;
          pend_valid <= 1'b0;
          fl_cnt     <= '0;
          unique case (act)
            wbsc_pkg::ACT_FLUSH: begin
              if (!persistence_on) begin
                resp  <= done_res;
                state <= S_RESP;
              end else begin
                state <= S_FLUSH;
              end
            end
            wbsc_pkg::ACT_READ, wbsc_pkg::ACT_WRITE: begin
              if (!in_range) begin
                resp  <= mk_res(wbsc_pkg::RES_RANGE, '0, 1'b0, '0, 1'b1);
                state <= S_RESP;
              end else if (!persistence_on) begin
                resp  <= mk_res(wbsc_pkg::RES_BYPASS, '0, 1'b0, '0, 1'b1);
                state <= S_RESP;
              end else begin
                state <= S_LOOK;
              end
            end
            wbsc_pkg::ACT_NONE: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_LOOK: begin
          if (look_match) begin
            resp <= hit_res;
            // A write hit on the pointer's slot moves the pointer past it.
            if (act == wbsc_pkg::ACT_WRITE && chk_idx == ptr) begin
              ptr <= ptr_inc;
            end
            state <= S_RESP;
          end else if (chk_last) begin
            if (act == wbsc_pkg::ACT_READ && !fetch) begin
              resp  <= mk_res(wbsc_pkg::RES_FETCH_FAIL, '0, 1'b0, '0, 1'b1);
              state <= S_RESP;
            end else begin
              state <= S_VICTIM;
            end
          end else begin
            chk_idx <= idx_inc;
          end
        end
        S_VICTIM: begin
          valid[ptr] <= 1'b1;
          ptr        <= ptr_inc;
          resp       <= fill_res;
          state      <= S_RESP;
        end
        S_FLUSH: begin
          if (!fl_stall) begin
            if (fl_hit) begin
              pend       <= entry_res;
              pend_valid <= 1'b1;
              fl_cnt     <= fl_cnt + 1'b1;
            end
            if (fl_done) begin
              state <= S_FLUSH_END;
            end else begin
              chk_idx <= idx_inc;
            end
          end
        end
        S_FLUSH_END: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // A result is only handed over when the output register can take it.
  `WBSC_ASSERT_IMPLY(a_push_free, clk, rst, push, out_free)
  // An allocation always leaves the allocated slot valid.
  `WBSC_ASSERT_NEXT(a_victim_valid, clk, rst, state == S_VICTIM, valid[$past(ptr)])
  // The flush walk stops before it exceeds its result budget.
  `WBSC_ASSERT_IMPLY(a_flush_cap, clk, rst, state == S_FLUSH, fl_cnt <= CAP_LAST)
  // The replacement pointer never leaves the slot range.
  `WBSC_ASSERT_ALWAYS(a_ptr_range, clk, rst, ptr <= LAST_IDX)

endmodule

### dv/write_back_sector_cache_fifo_unit_test.sv
// Self-checking testbench for the write-back sector cache controller, with a scoreboard class.
localparam int CACHE_SLOTS = 32;
localparam int DISK_CAPACITY = 1024;

// Tracks the tag, valid and dirty state of every slot and queues the results that
// each accepted item must produce.
class sector_cache_scoreboard;
  logic [wbsc_pkg::ESEC_W-1:0] tag_mem [CACHE_SLOTS];
  bit                          line_valid [CACHE_SLOTS];
  bit                          line_dirty [CACHE_SLOTS];
  int                          rr_ptr;
  bit                          persist;
  wbsc_pkg::result_t           due_results [$];
  int                          errors;
  int                          results_seen;
  int                          evictions;
  int                          act_count [4];
  int                          status_count [7];

  function new();
    foreach (tag_mem[i]) begin
      tag_mem[i] = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
    end
    rr_ptr = 0;
    persist = 1'b0;
    errors = 0;
    results_seen = 0;
    evictions = 0;
    foreach (act_count[i]) act_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  function wbsc_pkg::result_t make_result(wbsc_pkg::status_t st, int idx, bit ev,
                                          logic [wbsc_pkg::ESEC_W-1:0] esec, bit fin);
    wbsc_pkg::result_t r;
    r.status = st;
    r.slot = wbsc_pkg::SLOT_W'(idx);
    r.evict_valid = ev;
    r.evict_sector = ev ? esec : '0;
    r.last = fin;
    return r;
  endfunction

  // Take the replacement slot for a sector and report any dirty victim.
  function void allocate(logic [wbsc_pkg::ESEC_W-1:0] tag, bit make_dirty);
    int p;
    bit ev;
    p = rr_ptr;
    ev = line_valid[p] && line_dirty[p];
    if (ev) evictions++;
    due_results.push_back(make_result(wbsc_pkg::RES_FILLED, p, ev, tag_mem[p], 1'b1));
    tag_mem[p] = tag;
    line_valid[p] = 1'b1;
    line_dirty[p] = make_dirty;
    rr_ptr = (p + 1) % CACHE_SLOTS;
  endfunction

  // Work out the results of one accepted item and update the cache state.
  function void note_request(logic [wbsc_pkg::ACTION_W-1:0] act,
                             logic [wbsc_pkg::SECTOR_W-1:0] sec, bit f_ok, bit wb_ok);
    int hit;
    int found;
    bit have_entry;
    wbsc_pkg::result_t entry;
    act_count[act]++;
    if (act == wbsc_pkg::ACT_NONE) return;

    if (act == wbsc_pkg::ACT_FLUSH) begin
      if (!persist) begin
        due_results.push_back(make_result(wbsc_pkg::RES_FLUSH_DONE, 0, 1'b0, '0, 1'b1));
        return;
      end
      found = 0;
      have_entry = 1'b0;
      for (int i = 0; i < CACHE_SLOTS && found < wbsc_pkg::MAX_RESULTS; i++) begin
        if (line_valid[i] && line_dirty[i]) begin
          if (have_entry) due_results.push_back(entry);
          entry = make_result(wbsc_pkg::RES_FLUSH_ENTRY, i, 1'b1, tag_mem[i], 1'b0);
          have_entry = 1'b1;
          if (wb_ok) line_dirty[i] = 1'b0;
          found++;
        end
      end
      if (have_entry) begin
        entry.last = 1'b1;
        due_results.push_back(entry);
      end else begin
        due_results.push_back(make_result(wbsc_pkg::RES_FLUSH_DONE, 0, 1'b0, '0, 1'b1));
      end
      return;
    end

    if (sec >= DISK_CAPACITY) begin
      due_results.push_back(make_result(wbsc_pkg::RES_RANGE, 0, 1'b0, '0, 1'b1));
      return;
    end
    if (!persist) begin
      due_results.push_back(make_result(wbsc_pkg::RES_BYPASS, 0, 1'b0, '0, 1'b1));
      return;
    end

    // The lowest matching valid slot wins the lookup.
    hit = -1;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (line_valid[i] && tag_mem[i] == sec[wbsc_pkg::ESEC_W-1:0]) hit = i;
    end

    if (act == wbsc_pkg::ACT_READ) begin
      if (hit >= 0) begin
        due_results.push_back(make_result(wbsc_pkg::RES_HIT, hit, 1'b0, '0, 1'b1));
      end else if (f_ok) begin
        allocate(sec[wbsc_pkg::ESEC_W-1:0], 1'b0);
      end else begin
        due_results.push_back(make_result(wbsc_pkg::RES_FETCH_FAIL, 0, 1'b0, '0, 1'b1));
      end
    end else if (hit >= 0) begin
      line_dirty[hit] = 1'b1;
      if (hit == rr_ptr) rr_ptr = (hit + 1) % CACHE_SLOTS;
      due_results.push_back(make_result(wbsc_pkg::RES_HIT, hit, 1'b0, '0, 1'b1));
    end else begin
      allocate(sec[wbsc_pkg::ESEC_W-1:0], 1'b1);
    end
  endfunction

  function void report(string what, wbsc_pkg::result_t want, wbsc_pkg::result_t got);
    errors++;
    if (errors <= 10)
      $display("%s: expected status=%0d slot=%0d evict=%0b/%0d last=%0b, %s%0d %s%0d %s%0b/%0d %s%0b",
               what, want.status, want.slot, want.evict_valid, want.evict_sector, want.last,
               "got status=", got.status, "slot=", got.slot, "evict=", got.evict_valid,
               got.evict_sector, "last=", got.last);
  endfunction

  // Compare one accepted result with the oldest queued one.
  function void check_result(wbsc_pkg::result_t got);
    wbsc_pkg::result_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      report("Result with nothing pending", got, got);
      return;
    end
    want = due_results.pop_front();
    status_count[want.status]++;
    if (got.status !== want.status || got.slot !== want.slot ||
        got.evict_valid !== want.evict_valid || got.evict_sector !== want.evict_sector ||
        got.last !== want.last)
      report("Result mismatch", want, got);
  endfunction
endclass

module write_back_sector_cache_fifo_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_SETTLE = 48;
  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int POOL_SIZE = 48;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_data = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [wbsc_pkg::ACTION_W-1:0] action = wbsc_pkg::ACT_READ;
  logic [wbsc_pkg::SECTOR_W-1:0] sector = '0;
  logic                          fetch_ok = 1'b0;
  logic                          writeback_ok = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [wbsc_pkg::STATUS_W-1:0] status;
  logic [wbsc_pkg::SLOT_W-1:0]   slot;
  logic                          evict_valid;
  logic [wbsc_pkg::ESEC_W-1:0]   evict_sector;
  logic                          last;

  sector_cache_scoreboard sb = new();

  logic [wbsc_pkg::ESEC_W-1:0] sector_pool [POOL_SIZE];
  bit hold_req = 1'b0;
  int rx_hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_tick = 0;
  int idle_cycles = 0;

  write_back_sector_cache_fifo_unit #(
    .SLOTS(CACHE_SLOTS),
    .DISK_SIZE(DISK_CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .sector(sector),
    .fetch_ok(fetch_ok),
    .writeback_ok(writeback_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .slot(slot),
    .evict_valid(evict_valid),
    .evict_sector(evict_sector),
    .last(last)
  );

  always #5 clk = ~clk;

  // Observe every handshake at the clock edge and feed the scoreboard.
  always @(posedge clk) begin : monitor_b
    wbsc_pkg::result_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.persist = cfg_data;
      if (out_valid && !out_stall) begin
        seen.status = wbsc_pkg::status_t'(status);
        seen.slot = slot;
        seen.evict_valid = evict_valid;
        seen.evict_sector = evict_sector;
        seen.last = last;
        sb.check_result(seen);
      end
      if (in_valid && !in_stall) sb.note_request(action, sector, fetch_ok, writeback_ok);
    end
  end

  // Receiver stall pattern: random modes of varying length, plus one long hold-off.
  always @(posedge clk) begin
    rx_tick++;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      rx_hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= (rx_tick % 3 == 0);
      endcase
    end
  end

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results pending",
               idle_cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one item and hold it until it is accepted.
  task automatic send_item(input logic [wbsc_pkg::ACTION_W-1:0] act,
                           input logic [wbsc_pkg::SECTOR_W-1:0] sec,
                           input bit f_ok, input bit wb_ok);
    in_valid <= 1'b1;
    action <= act;
    sector <= sec;
    fetch_ok <= f_ok;
    writeback_ok <= wb_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until the block is idle, then write the persistence register.
  task automatic write_persistence(input bit value);
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random items in bursts; most sectors come from a small pool so hits and
  // dirty evictions are frequent.
  task automatic run_random(input int count);
    int sent;
    int burst;
    int gap;
    int pick;
    logic [wbsc_pkg::ACTION_W-1:0] act;
    logic [wbsc_pkg::SECTOR_W-1:0] sec;
    bit f_ok;
    bit wb_ok;
    foreach (sector_pool[i])
      sector_pool[i] = wbsc_pkg::ESEC_W'($urandom_range(0, DISK_CAPACITY - 1));
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) act = wbsc_pkg::ACT_READ;
        else if (pick < 85) act = wbsc_pkg::ACT_WRITE;
        else if (pick < 96) act = wbsc_pkg::ACT_FLUSH;
        else act = wbsc_pkg::ACT_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          sec = wbsc_pkg::SECTOR_W'(sector_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end else if (pick < 80) begin
          sec = wbsc_pkg::SECTOR_W'($urandom_range(0, DISK_CAPACITY - 1));
        end else if (pick < 90) begin
          sec = wbsc_pkg::SECTOR_W'($urandom);
        end else begin
          case ($urandom_range(0, 3))
            0: sec = '0;
            1: sec = wbsc_pkg::SECTOR_W'(DISK_CAPACITY - 1);
            2: sec = wbsc_pkg::SECTOR_W'(DISK_CAPACITY);
            default: sec = '1;
          endcase
        end
        f_ok = ($urandom_range(0, 3) != 0);
        wb_ok = ($urandom_range(0, 1) == 1);
        send_item(act, sec, f_ok, wb_ok);
        if (act != wbsc_pkg::ACT_NONE) sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Persistence off: in-range accesses bypass, out-of-range ones are rejected, a flush reports done.
    write_persistence(1'b0);
    send_item(wbsc_pkg::ACT_READ, '0, 1'b1, 1'b1);
    send_item(wbsc_pkg::ACT_WRITE, wbsc_pkg::SECTOR_W'(DISK_CAPACITY - 1), 1'b0, 1'b0);
    send_item(wbsc_pkg::ACT_READ, wbsc_pkg::SECTOR_W'(DISK_CAPACITY), 1'b1, 1'b0);
    send_item(wbsc_pkg::ACT_WRITE, '1, 1'b1, 1'b1);
    send_item(wbsc_pkg::ACT_FLUSH, '0, 1'b0, 1'b1);
    send_item(wbsc_pkg::ACT_NONE, 16'h5A5A, 1'b1, 1'b1);
    in_valid <= 1'b0;

    // Persistence on: empty flush, failed fetch, fill, hits, write misses, out-of-range items and flushes.
    write_persistence(1'b1);
    send_item(wbsc_pkg::ACT_FLUSH, '0, 1'b1, 1'b1);
    send_item(wbsc_pkg::ACT_READ, 16'd5, 1'b0, 1'b0);
    send_item(wbsc_pkg::ACT_READ, 16'd5, 1'b1, 1'b0);
    send_item(wbsc_pkg::ACT_READ, 16'd5, 1'b0, 1'b0);
    send_item(wbsc_pkg::ACT_WRITE, 16'd5, 1'b0, 1'b1);
    send_item(wbsc_pkg::ACT_WRITE, wbsc_pkg::SECTOR_W'(DISK_CAPACITY - 1), 1'b0, 1'b0);
    send_item(wbsc_pkg::ACT_READ, wbsc_pkg::SECTOR_W'(DISK_CAPACITY), 1'b1, 1'b1);
    send_item(wbsc_pkg::ACT_WRITE, '1, 1'b1, 1'b1);
    send_item(wbsc_pkg::ACT_NONE, '0, 1'b0, 1'b0);
    send_item(wbsc_pkg::ACT_FLUSH, '1, 1'b1, 1'b0);
    send_item(wbsc_pkg::ACT_FLUSH, '0, 1'b0, 1'b1);
    send_item(wbsc_pkg::ACT_FLUSH, '0, 1'b1, 1'b1);
    send_item(wbsc_pkg::ACT_READ, '0, 1'b1, 1'b0);
    send_item(wbsc_pkg::ACT_WRITE, 16'd682, 1'b1, 1'b0);

    // Random traffic with caching on, then bypassed, then on again under a
    // long receiver hold-off that backs the block up.
    run_random(200);
    write_persistence(1'b0);
    run_random(50);
    write_persistence(1'b1);
    hold_req = 1'b1;
    run_random(160);

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.errors += sb.pending();

    $display("Run covered %0d reads, %0d writes, %0d flushes and %0d ignored items; %0d results.",
             sb.act_count[wbsc_pkg::ACT_READ], sb.act_count[wbsc_pkg::ACT_WRITE],
             sb.act_count[wbsc_pkg::ACT_FLUSH], sb.act_count[wbsc_pkg::ACT_NONE],
             sb.results_seen);
    $display("Hits %0d, fills %0d (%0d dirty victims), range %0d, bypass %0d, %s%0d, %s%0d %s%0d",
             sb.status_count[wbsc_pkg::RES_HIT], sb.status_count[wbsc_pkg::RES_FILLED],
             sb.evictions, sb.status_count[wbsc_pkg::RES_RANGE],
             sb.status_count[wbsc_pkg::RES_BYPASS],
             "fetch failures ", sb.status_count[wbsc_pkg::RES_FETCH_FAIL],
             "flushed entries ", sb.status_count[wbsc_pkg::RES_FLUSH_ENTRY],
             "empty flushes ", sb.status_count[wbsc_pkg::RES_FLUSH_DONE]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Failures: %0d", sb.errors);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
